>>> hdl/tgarle_pkg.sv
// Shared types and constants for the TGA run-length pixel decoder.
// No dependencies; compiled first.
package tgarle_pkg;

    localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd2;
    localparam logic [2:0] REG_COMPRESSED      = 3'd3;
    localparam logic [2:0] REG_RIGHT_TO_LEFT   = 3'd4;
    localparam logic [2:0] REG_ROWS_DOWNWARD   = 3'd5;

    localparam logic [7:0] HDR_RUN_MASK   = 8'h80;
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7F;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic        compressed;
        logic        right_to_left;
        logic        rows_downward;
    } t_cfg;

    typedef struct packed {
        logic [16:0] row_room;
        logic [15:0] start_column;
        logic [15:0] canvas_row;
        logic [15:0] next_column;
        logic [15:0] next_row;
        logic        image_done;
    } t_place;

endpackage

>>> hdl/tgarle_if.sv
// Channel interfaces: byte input, result output and register write.
// Depends on nothing; compiled after tgarle_pkg.
interface tgarle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface tgarle_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pix_word;
    logic [15:0] start_column;
    logic [15:0] canvas_row;
    logic [7:0]  run_length;
    logic        row_clipped;
    logic        image_done;
    modport source (output valid, output pix_word, output start_column,
                    output canvas_row, output run_length, output row_clipped,
                    output image_done, input ready);
    modport sink (input valid, input pix_word, input start_column,
                  input canvas_row, input run_length, input row_clipped,
                  input image_done, output ready);
endinterface

interface tgarle_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hdl/tgarle_place.sv
// Canvas placement: row room, flipped position and counter advance for one run.
// Depends on tgarle_pkg.
module tgarle_place
    import tgarle_pkg::*;
(
    input  t_cfg        i_cfg,
    input  logic [15:0] i_column_count,
    input  logic [15:0] i_row_count,
    input  logic [7:0]  i_run_length,
    output t_place      o_place
);
    logic [16:0] w_width;
    logic [16:0] w_height;
    logic [16:0] w_next_col;
    logic [16:0] w_next_row;

    always_comb begin
        w_width  = (i_cfg.image_width == 16'd0) ? 17'h10000 : {1'b0, i_cfg.image_width};
        w_height = (i_cfg.image_height == 16'd0) ? 17'h10000 : {1'b0, i_cfg.image_height};
        w_next_col = {1'b0, i_column_count} + {9'd0, i_run_length};
        w_next_row = {1'b0, i_row_count} + 17'd1;

        o_place.row_room = ({1'b0, i_column_count} < w_width)
                         ? (w_width - {1'b0, i_column_count}) : 17'd1;
        o_place.start_column = i_cfg.right_to_left
                             ? (i_cfg.image_width - 16'd1 - i_column_count) : i_column_count;
        o_place.canvas_row = i_cfg.rows_downward
                           ? i_row_count : (i_cfg.image_height - 16'd1 - i_row_count);

        o_place.image_done  = 1'b0;
        o_place.next_row    = i_row_count;
        o_place.next_column = w_next_col[15:0];
        if (w_next_col >= w_width) begin
            o_place.next_column = 16'd0;
            o_place.next_row    = w_next_row[15:0];
            if (w_next_row >= w_height) begin
                o_place.next_row   = 16'd0;
                o_place.image_done = 1'b1;
            end
        end
    end
endmodule

>>> hdl/tga_rle_pixel_decoder_unit.sv
// Top level of the TGA run-length pixel decoder: packet parse, pixel gather, result register.
// Depends on tgarle_pkg, tgarle_if and tgarle_place.
//
//   channel  dir  width  payload
//   i_in     in   8      data_byte
//   o_out    out  74     pix_word, start_column, canvas_row, run_length,
//                        row_clipped, image_done
//   i_cfg    in   19     index, data (always ready)
//
// One byte per cycle while ready; a result shows in the cycle after its last byte.
// Input ready drops only while the result register is full and not taken.
// Synchronous active-low reset restores register defaults and packet state.
module tga_rle_pixel_decoder_unit
    import tgarle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    tgarle_byte_if.sink         i_in,
    tgarle_pix_if.source        o_out,
    tgarle_cfg_if.sink          i_cfg
);
    t_cfg        r_cfg;
    logic        r_expect_header, n_expect_header;
    logic        r_packet_is_run, n_packet_is_run;
    logic [7:0]  r_packet_left,   n_packet_left;
    logic [1:0]  r_byte_pos,      n_byte_pos;
    logic [31:0] r_gather,        n_gather;
    logic [15:0] r_col_count,     n_col_count;
    logic [15:0] r_row_count,     n_row_count;
    logic        r_drop_rest,     n_drop_rest;

    logic        r_out_valid;
    logic [31:0] r_pix_word;
    logic [15:0] r_start_column;
    logic [15:0] r_canvas_row;
    logic [7:0]  r_run_length;
    logic        r_row_clipped;
    logic        r_image_done;

    logic        w_accept;
    logic        w_emit;
    logic [1:0]  w_last_pos;
    logic [31:0] w_full;
    logic [31:0] w_value;
    logic [7:0]  w_len;
    logic        w_clip;
    logic [7:0]  w_want;
    logic [7:0]  w_left_dec;
    t_place      w_place;

    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    tgarle_place u_place (
        .i_cfg          (r_cfg),
        .i_column_count (r_col_count),
        .i_row_count    (r_row_count),
        .i_run_length   (w_len),
        .o_place        (w_place)
    );

    always_comb begin
        case (r_cfg.bytes_per_pixel)
            3'd0, 3'd1: w_last_pos = 2'd0;
            3'd2:       w_last_pos = 2'd1;
            3'd3:       w_last_pos = 2'd2;
            default:    w_last_pos = 2'd3;
        endcase
        w_full     = r_gather | ({24'd0, i_in.data_byte} << {r_byte_pos, 3'b000});
        w_want     = (r_packet_left == 8'd0) ? 8'd1 : r_packet_left;
        w_left_dec = (r_packet_left == 8'd0) ? 8'd0 : (r_packet_left - 8'd1);

        n_expect_header = r_expect_header;
        n_packet_is_run = r_packet_is_run;
        n_packet_left   = r_packet_left;
        n_byte_pos      = r_byte_pos;
        n_gather        = r_gather;
        n_drop_rest     = r_drop_rest;
        w_emit  = 1'b0;
        w_len   = 8'd1;
        w_clip  = 1'b0;
        w_value = w_full;

        if (w_accept) begin
            if (r_cfg.compressed && r_expect_header) begin
                n_packet_is_run = (i_in.data_byte & HDR_RUN_MASK) != 8'd0;
                n_packet_left   = (i_in.data_byte & HDR_COUNT_MASK) + 8'd1;
                n_expect_header = 1'b0;
                n_drop_rest     = 1'b0;
                n_byte_pos      = 2'd0;
                n_gather        = 32'd0;
            end else if (r_byte_pos < w_last_pos) begin
                n_gather   = w_full;
                n_byte_pos = r_byte_pos + 2'd1;
            end else begin
                n_byte_pos = 2'd0;
                n_gather   = 32'd0;
                if (!r_cfg.compressed) begin
                    w_emit = 1'b1;
                end else begin
                    if (w_last_pos == 2'd3) begin
                        w_value = {w_full[31:24], w_full[7:0], w_full[15:8], w_full[23:16]};
                    end
                    if (r_packet_is_run) begin
                        if ({9'd0, w_want} < w_place.row_room) begin
                            w_len = w_want;
                        end else begin
                            w_len = w_place.row_room[7:0];
                        end
                        w_clip          = {9'd0, w_want} > w_place.row_room;
                        n_packet_left   = 8'd0;
                        n_expect_header = 1'b1;
                        w_emit          = 1'b1;
                    end else begin
                        if (!r_drop_rest) begin
                            w_clip = (w_place.row_room == 17'd1) && (r_packet_left > 8'd1);
                            w_emit = 1'b1;
                            if (w_clip) begin
                                n_drop_rest = 1'b1;
                            end
                        end
                        n_packet_left = w_left_dec;
                        if (w_left_dec == 8'd0) begin
                            n_expect_header = 1'b1;
                            n_drop_rest     = 1'b0;
                        end
                    end
                end
            end
        end

        n_col_count = w_emit ? w_place.next_column : r_col_count;
        n_row_count = w_emit ? w_place.next_row : r_row_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= 16'd1;
            r_cfg.image_height    <= 16'd1;
            r_cfg.bytes_per_pixel <= 3'd1;
            r_cfg.compressed      <= 1'b1;
            r_cfg.right_to_left   <= 1'b0;
            r_cfg.rows_downward   <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_IMAGE_WIDTH:     r_cfg.image_width     <= i_cfg.data;
                REG_IMAGE_HEIGHT:    r_cfg.image_height    <= i_cfg.data;
                REG_BYTES_PER_PIXEL: r_cfg.bytes_per_pixel <= i_cfg.data[2:0];
                REG_COMPRESSED:      r_cfg.compressed      <= i_cfg.data[0];
                REG_RIGHT_TO_LEFT:   r_cfg.right_to_left   <= i_cfg.data[0];
                REG_ROWS_DOWNWARD:   r_cfg.rows_downward   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header <= 1'b1;
            r_packet_is_run <= 1'b0;
            r_packet_left   <= 8'd0;
            r_byte_pos      <= 2'd0;
            r_gather        <= 32'd0;
            r_col_count     <= 16'd0;
            r_row_count     <= 16'd0;
            r_drop_rest     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_expect_header <= n_expect_header;
            r_packet_is_run <= n_packet_is_run;
            r_packet_left   <= n_packet_left;
            r_byte_pos      <= n_byte_pos;
            r_gather        <= n_gather;
            r_col_count     <= n_col_count;
            r_row_count     <= n_row_count;
            r_drop_rest     <= n_drop_rest;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_pix_word     <= w_value;
            r_start_column <= w_place.start_column;
            r_canvas_row   <= w_place.canvas_row;
            r_run_length   <= w_len;
            r_row_clipped  <= w_clip;
            r_image_done   <= w_place.image_done;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pix_word     = r_pix_word;
    assign o_out.start_column = r_start_column;
    assign o_out.canvas_row   = r_canvas_row;
    assign o_out.run_length   = r_run_length;
    assign o_out.row_clipped  = r_row_clipped;
    assign o_out.image_done   = r_image_done;
endmodule
